FILE: hdl/ufaf_pkg.sv
// Package for the UTF-8 fullwidth to ASCII fold block.
// Holds the payload structs, the queue entry type and the lead and fold table functions.
// No dependencies.
`default_nettype none

package ufaf_pkg;

  localparam int unsigned MaxSeqBytes = 6;
  localparam int unsigned HeldBytes   = 5;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_text_end;
  } ufaf_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_run_last;
    logic       out_text_end;
  } ufaf_out_t;

  // One finished sequence, ready to be written out byte by byte.
  typedef struct packed {
    logic [MaxSeqBytes-1:0][7:0] bytes;
    logic [2:0]                  cnt;
    logic                        text_end;
  } ufaf_job_t;

  localparam logic [7:0] LeadE2   = 8'hE2;
  localparam logic [7:0] LeadE3   = 8'hE3;
  localparam logic [7:0] LeadEF   = 8'hEF;
  localparam logic [7:0] MidBC    = 8'hBC;
  localparam logic [7:0] MidBD    = 8'hBD;
  localparam logic [7:0] Mid80    = 8'h80;
  localparam logic [7:0] NoHit    = 8'h00;

  // Sequence length announced by a lead byte; invalid leads count as one.
  function automatic logic [2:0] ufaf_lead_length(input logic [7:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0)                    len = 3'd1;
    else if ((b & 8'hE0) == 8'hC0)       len = 3'd2;
    else if ((b & 8'hF0) == 8'hE0)       len = 3'd3;
    else if ((b & 8'hF8) == 8'hF0)       len = 3'd4;
    else if ((b & 8'hFC) == 8'hF8)       len = 3'd5;
    else if ((b & 8'hFE) == 8'hFC)       len = 3'd6;
    else                                 len = 3'd1;
    return len;
  endfunction

  // Fullwidth fold table; NoHit when the sequence is not listed.
  function automatic logic [7:0] ufaf_fold(input logic [7:0] b1, input logic [7:0] b2,
                                           input logic [7:0] b3);
    logic [7:0] r;
    r = NoHit;
    if (b1 == LeadE2 && b2 == Mid80 && (b3 == 8'h9C || b3 == 8'h9D)) begin
      r = 8'h22;
    end else if (b1 == LeadE3 && b2 == Mid80) begin
      case (b3)
        8'h80:   r = 8'h20;
        8'h94:   r = 8'h5B;
        8'h95:   r = 8'h5D;
        default: r = NoHit;
      endcase
    end else if (b1 == LeadEF && b2 == MidBC) begin
      case (b3)
        8'h8C:   r = 8'h2C;
        8'h8E:   r = 8'h2E;
        8'h9A:   r = 8'h3A;
        8'h9B:   r = 8'h3B;
        8'h9F:   r = 8'h3F;
        8'h81:   r = 8'h21;
        8'hA0:   r = 8'h40;
        8'h88:   r = 8'h28;
        8'h89:   r = 8'h29;
        8'hBB:   r = 8'h5B;
        8'hBD:   r = 8'h5D;
        default: begin
          if (b3 >= 8'h90 && b3 <= 8'h99)      r = 8'h30 + (b3 - 8'h90);
          else if (b3 >= 8'hA1 && b3 <= 8'hBA) r = 8'h61 + (b3 - 8'hA1);
          else                                 r = NoHit;
        end
      endcase
    end else if (b1 == LeadEF && b2 == MidBD) begin
      if (b3 == 8'h9B)                     r = 8'h7B;
      else if (b3 == 8'h9D)                r = 8'h7D;
      else if (b3 >= 8'h81 && b3 <= 8'h9A) r = 8'h61 + (b3 - 8'h81);
      else                                 r = NoHit;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/utf8_fullwidth_ascii_fold.sv
// UTF-8 fullwidth to halfwidth lowercase ASCII fold, top level.
// A byte that ends a sequence writes its job into the job queue when it is accepted.
// Input: one byte per cycle while not full; output: one byte per pop, n pops per n-byte job.
// The job queue (QueueDepth entries) lets the front keep accepting while results wait.
// Reset: asynchronous, active low; no sequence open, queue empty, held bytes left as they are.
// Depends on ufaf_pkg, ufaf_front, ufaf_queue and ufaf_back.
`default_nettype none

module utf8_fullwidth_ascii_fold #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Input side: queue-style push
  input  wire logic               push,
  output logic                    full,
  input  wire ufaf_pkg::ufaf_in_t in_i,
  // Result side: queue-style pop
  output logic                    empty,
  input  wire logic               pop,
  output ufaf_pkg::ufaf_out_t     out_o
);
  import ufaf_pkg::*;

  logic      accept;
  logic      enq;
  ufaf_job_t enq_job;
  logic      deq;
  logic      head_valid;
  ufaf_job_t head_job;

  // Take a request whenever the job queue has room; held bytes need no slot, but
  // keep the rule simple so full never depends on the incoming byte.
  assign accept = push && !full;

  // Collect lead and continuation bytes, fold table hits, lowercase ASCII.
  ufaf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_i),
    .enq_o    (enq),
    .job_o    (enq_job)
  );

  // Decouple sequence completion from result drain.
  ufaf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .enq_i   (enq),
    .job_i   (enq_job),
    .full_o  (full),
    .deq_i   (deq),
    .valid_o (head_valid),
    .head_o  (head_job)
  );

  // Hand out the head job one byte per pop request.
  ufaf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (head_valid),
    .head_i  (head_job),
    .deq_o   (deq),
    .pop_i   (pop),
    .empty_o (empty),
    .out_o   (out_o)
  );

  // A drained job always ends on its last byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq |-> (pop && !empty && out_o.out_run_last))
    else $error("top: job released before its last byte was taken");

endmodule

`default_nettype wire

FILE: hdl/ufaf_front.sv
// Front end of the fold block: collects UTF-8 sequences and classifies them.
// Emits one finished job per complete or cut-off sequence. Depends on ufaf_pkg.
`default_nettype none

module ufaf_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire ufaf_pkg::ufaf_in_t in_i,
  output logic                   enq_o,
  output ufaf_pkg::ufaf_job_t    job_o
);
  import ufaf_pkg::*;

  logic [2:0] seq_len_q, seq_len_d;
  logic [2:0] coll_q, coll_d;
  logic [7:0] held_q [HeldBytes];
  logic       wr_en;
  logic [2:0] wr_idx;
  logic [2:0] lead_len;
  logic [2:0] n_bytes;
  logic       cont_ok;
  logic [7:0] fold_byte;
  logic [7:0] b;

  assign b         = in_i.in_byte;
  assign lead_len  = ufaf_lead_length(b);
  assign n_bytes   = coll_q + 3'd1;
  assign fold_byte = ufaf_fold(held_q[0], held_q[1], b);

  // Check every byte after the lead for the continuation pattern.
  always_comb begin
    cont_ok = (b[7:6] == 2'b10);
    for (int i = 1; i < HeldBytes; i++) begin
      if (3'(i) < coll_q && held_q[i][7:6] != 2'b10) cont_ok = 1'b0;
    end
  end

  always_comb begin
    seq_len_d = seq_len_q;
    coll_d    = coll_q;
    wr_en     = 1'b0;
    wr_idx    = coll_q;
    enq_o     = 1'b0;
    for (int i = 0; i < HeldBytes; i++) begin
      job_o.bytes[i] = (3'(i) < coll_q) ? held_q[i] : b;
    end
    job_o.bytes[MaxSeqBytes-1] = b;
    job_o.cnt      = n_bytes;
    job_o.text_end = in_i.in_text_end;

    if (accept_i) begin
      if (seq_len_q == 3'd0) begin
        job_o.cnt = 3'd1;
        if (lead_len == 3'd1) begin
          enq_o          = 1'b1;
          job_o.bytes[0] = (b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;
        end else if (in_i.in_text_end) begin
          enq_o          = 1'b1;
          job_o.bytes[0] = b;
        end else begin
          wr_en     = 1'b1;
          wr_idx    = 3'd0;
          seq_len_d = lead_len;
          coll_d    = 3'd1;
        end
      end else if (n_bytes < seq_len_q && !in_i.in_text_end) begin
        wr_en  = 1'b1;
        coll_d = n_bytes;
      end else begin
        seq_len_d = 3'd0;
        coll_d    = 3'd0;
        enq_o     = 1'b1;
        if (n_bytes >= seq_len_q && cont_ok && n_bytes == 3'd3 && fold_byte != NoHit) begin
          job_o.bytes[0] = fold_byte;
          job_o.cnt      = 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q <= 3'd0;
      coll_q    <= 3'd0;
    end else begin
      seq_len_q <= seq_len_d;
      coll_q    <= coll_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      held_q[wr_idx] <= b;
    end
  end

  // An open sequence always holds at least its lead and is never complete.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_len_q != 3'd0 |-> (coll_q != 3'd0 && coll_q < seq_len_q))
    else $error("front: collected count out of range for open sequence");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_len_q == 3'd0 |-> coll_q == 3'd0)
    else $error("front: bytes held with no open sequence");

endmodule

`default_nettype wire

FILE: hdl/ufaf_queue.sv
// Job queue between the front and back ends of the fold block.
// Flop-based FIFO of finished sequences. Depends on ufaf_pkg.
`default_nettype none

module ufaf_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                enq_i,
  input  wire ufaf_pkg::ufaf_job_t job_i,
  output logic                     full_o,
  input  wire logic                deq_i,
  output logic                     valid_o,
  output ufaf_pkg::ufaf_job_t      head_o
);
  import ufaf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ufaf_job_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_deq;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_deq  = deq_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (enq_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_deq) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (enq_i && !do_deq)      count_d = count_q + CntW'(1);
    else if (!enq_i && do_deq) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq_i |-> !full_o)
    else $error("queue: write while full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue: occupancy above depth");

endmodule

`default_nettype wire

FILE: hdl/ufaf_back.sv
// Back end of the fold block: walks the head job and presents one byte per request.
// Marks the last byte of each job and the end of text. Depends on ufaf_pkg.
`default_nettype none

module ufaf_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire ufaf_pkg::ufaf_job_t head_i,
  output logic                     deq_o,
  input  wire logic                pop_i,
  output logic                     empty_o,
  output ufaf_pkg::ufaf_out_t      out_o
);
  import ufaf_pkg::*;

  logic [2:0] idx_q, idx_d;
  logic       last;
  logic       take;

  assign empty_o = !valid_i;
  assign last    = (idx_q == head_i.cnt - 3'd1);
  assign take    = pop_i && valid_i;
  assign deq_o   = take && last;

  assign out_o.out_byte     = head_i.bytes[idx_q];
  assign out_o.out_run_last = last;
  assign out_o.out_text_end = last && head_i.text_end;

  // Advance within the job; return to the first byte when the job is done.
  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = last ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 3'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (head_i.cnt != 3'd0 && idx_q < head_i.cnt))
    else $error("back: byte index beyond job length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_i |-> idx_q == 3'd0)
    else $error("back: partial job left with queue empty");

endmodule

`default_nettype wire

FILE: verif/ufaf_checker.sv
// Checker for the UTF-8 fullwidth to ASCII fold block: watches both queue ports.
// Predicts each result from accepted input requests and compares them in order.
// Depends on ufaf_pkg for the payload types and the table lead/middle byte constants.
`timescale 1ns / 100ps

module ufaf_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                full_i,
  input  ufaf_pkg::ufaf_in_t  req_i,
  input  logic                empty_i,
  input  logic                pop_i,
  input  ufaf_pkg::ufaf_out_t res_i,
  output int                  err_cnt_o,
  output int                  pending_o,
  output int                  items_o,
  output int                  results_o,
  output int                  folds_o,
  output int                  ends_o
);

  import ufaf_pkg::*;

  // Predictor state: bytes of the open sequence, its length, bytes held so far.
  logic [7:0] seq_held [HeldBytes];
  int         open_len   = 0;
  int         held_cnt   = 0;

  ufaf_out_t  folded_bytes_q [$];

  initial begin
    err_cnt_o = 0;
    pending_o = 0;
    items_o   = 0;
    results_o = 0;
    folds_o   = 0;
    ends_o    = 0;
  end

  function automatic int seq_len_of(input logic [7:0] b);
    casez (b)
      8'b0???????: return 1;
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      8'b111110??: return 5;
      8'b1111110?: return 6;
      default:     return 1;
    endcase
  endfunction

  // Fullwidth table; NoHit when the three bytes are not listed.
  function automatic logic [7:0] fullwidth_to_ascii(input logic [7:0] b1, input logic [7:0] b2,
                                                    input logic [7:0] b3);
    logic [7:0] a;
    a = NoHit;
    if (b1 == LeadE2 && b2 == Mid80) begin
      if (b3 == 8'h9C || b3 == 8'h9D) a = 8'h22;
    end else if (b1 == LeadE3 && b2 == Mid80) begin
      case (b3)
        8'h80:   a = 8'h20;
        8'h94:   a = 8'h5B;
        8'h95:   a = 8'h5D;
        default: a = NoHit;
      endcase
    end else if (b1 == LeadEF && b2 == MidBC) begin
      case (b3)
        8'h81:   a = 8'h21;
        8'h88:   a = 8'h28;
        8'h89:   a = 8'h29;
        8'h8C:   a = 8'h2C;
        8'h8E:   a = 8'h2E;
        8'h9A:   a = 8'h3A;
        8'h9B:   a = 8'h3B;
        8'h9F:   a = 8'h3F;
        8'hA0:   a = 8'h40;
        8'hBB:   a = 8'h5B;
        8'hBD:   a = 8'h5D;
        default: begin
          if (b3 >= 8'h90 && b3 <= 8'h99) a = 8'h30 + (b3 - 8'h90);
          else if (b3 >= 8'hA1 && b3 <= 8'hBA) a = 8'h61 + (b3 - 8'hA1);
        end
      endcase
    end else if (b1 == LeadEF && b2 == MidBD) begin
      if (b3 == 8'h9B) a = 8'h7B;
      else if (b3 == 8'h9D) a = 8'h7D;
      else if (b3 >= 8'h81 && b3 <= 8'h9A) a = 8'h61 + (b3 - 8'h81);
    end
    return a;
  endfunction

  function automatic ufaf_out_t make_result(input logic [7:0] b, input logic last,
                                            input logic text_end);
    ufaf_out_t r;
    r.out_byte     = b;
    r.out_run_last = last;
    r.out_text_end = last & text_end;
    return r;
  endfunction

  task automatic predict_fold(input ufaf_in_t req);
    logic [7:0] seq [MaxSeqBytes];
    logic [7:0] b;
    logic [7:0] hit;
    logic       well_formed;
    int         n;
    int         len;
    b = req.in_byte;
    if (open_len == 0) begin
      len = seq_len_of(b);
      if (len == 1) begin
        if (b >= 8'h41 && b <= 8'h5A) b = b + 8'd32;
        folded_bytes_q.push_back(make_result(b, 1'b1, req.in_text_end));
      end else if (req.in_text_end) begin
        folded_bytes_q.push_back(make_result(b, 1'b1, 1'b1));
      end else begin
        seq_held[0] = b;
        open_len    = len;
        held_cnt    = 1;
      end
      return;
    end
    n = held_cnt;
    for (int i = 0; i < n; i++) seq[i] = seq_held[i];
    seq[n] = b;
    n++;
    if (n < open_len && !req.in_text_end) begin
      seq_held[n-1] = b;
      held_cnt      = n;
      return;
    end
    len      = open_len;
    open_len = 0;
    held_cnt = 0;
    if (n == len && n == 3) begin
      well_formed = (seq[1][7:6] == 2'b10) && (seq[2][7:6] == 2'b10);
      hit = fullwidth_to_ascii(seq[0], seq[1], seq[2]);
      if (well_formed && hit != NoHit) begin
        folded_bytes_q.push_back(make_result(hit, 1'b1, req.in_text_end));
        folds_o++;
        return;
      end
    end
    // Pass the whole sequence through: malformed, truncated or no table hit.
    for (int i = 0; i < n; i++)
      folded_bytes_q.push_back(make_result(seq[i], i == n - 1, req.in_text_end));
  endtask

  always @(posedge clk_i) begin
    ufaf_out_t want;
    if (rst_ni) begin
      if (push_i && !full_i) begin
        predict_fold(req_i);
        items_o++;
        if (req_i.in_text_end) ends_o++;
      end
      if (pop_i && !empty_i) begin
        results_o++;
        if (folded_bytes_q.size() == 0) begin
          err_cnt_o++;
          $display("%0t: unexpected result byte %h last %b end %b", $time,
                   res_i.out_byte, res_i.out_run_last, res_i.out_text_end);
        end else begin
          want = folded_bytes_q.pop_front();
          if (res_i.out_byte !== want.out_byte || res_i.out_run_last !== want.out_run_last ||
              res_i.out_text_end !== want.out_text_end) begin
            err_cnt_o++;
            $display("%0t: result %0d mismatch: expected byte %h last %b end %b, got %h %b %b",
                     $time, results_o, want.out_byte, want.out_run_last, want.out_text_end,
                     res_i.out_byte, res_i.out_run_last, res_i.out_text_end);
          end
        end
      end
      pending_o = folded_bytes_q.size();
    end
  end

endmodule

FILE: verif/tb_top.sv
// Top of the testbench for utf8_fullwidth_ascii_fold: clock, reset, stimulus and verdict.
// Drives push requests in bursts and pops results on its own stall pattern.
// Depends on ufaf_pkg, the block itself and ufaf_checker.
`timescale 1ns / 100ps

module tb_top;

  import ufaf_pkg::*;

  localparam int ClkHalf     = 5;
  localparam int ResetCycles = 12;
  localparam int RandomBytes = 500;
  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 16;

  typedef enum int {RxFree, RxCoin, RxComb, RxLong} rx_mode_e;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push   = 1'b0;
  logic      pop    = 1'b0;
  logic      full;
  logic      empty;
  ufaf_in_t  in_i   = '0;
  ufaf_out_t out_o;

  int err_cnt;
  int pending;
  int items;
  int results;
  int folds;
  int ends;

  ufaf_in_t text_q [$];

  always #(ClkHalf) clk_i = ~clk_i;

  utf8_fullwidth_ascii_fold u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .in_i   (in_i),
    .empty  (empty),
    .pop    (pop),
    .out_o  (out_o)
  );

  ufaf_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_i    (full),
    .req_i     (in_i),
    .empty_i   (empty),
    .pop_i     (pop),
    .res_i     (out_o),
    .err_cnt_o (err_cnt),
    .pending_o (pending),
    .items_o   (items),
    .results_o (results),
    .folds_o   (folds),
    .ends_o    (ends)
  );

  // Append one byte of text to the stimulus queue.
  task automatic add_byte(input logic [7:0] b, input logic text_end);
    ufaf_in_t req;
    req.in_byte     = b;
    req.in_text_end = text_end;
    text_q.push_back(req);
  endtask

  // Random text bytes end the text now and then, which also cuts open sequences short.
  task automatic add_rand_byte(input logic [7:0] b);
    add_byte(b, $urandom_range(0, 19) == 0);
  endtask

  task automatic build_directed;
    // Lone ASCII at the edges of the uppercase range, zero and the top code.
    add_byte(8'h41, 1'b0);
    add_byte(8'h5A, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h7F, 1'b0);
    // Invalid lead bytes, the second one closing a text.
    add_byte(8'hFF, 1'b0);
    add_byte(8'h80, 1'b1);
    // Table hits: first and last fullwidth letter, a curly quote.
    add_byte(8'hEF, 1'b0); add_byte(8'hBC, 1'b0); add_byte(8'hA1, 1'b0);
    add_byte(8'hEF, 1'b0); add_byte(8'hBD, 1'b0); add_byte(8'h9A, 1'b0);
    add_byte(8'hE2, 1'b0); add_byte(8'h80, 1'b0); add_byte(8'h9D, 1'b1);
    // Malformed 3-byte sequence: continuation bytes are plain ASCII.
    add_byte(8'hE3, 1'b0); add_byte(8'h41, 1'b0); add_byte(8'h42, 1'b0);
    // Truncated 4-byte sequence at the end of the text.
    add_byte(8'hF0, 1'b0); add_byte(8'h9F, 1'b1);
    // Longest sequence, six bytes passed through.
    add_byte(8'hFC, 1'b0);
    for (int i = 0; i < 5; i++) add_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
  endtask

  task automatic build_random;
    int          kind;
    int          len;
    logic [7:0]  lead;
    logic [7:0]  mid;
    int          start;
    start = text_q.size();
    while (text_q.size() - start < RandomBytes) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        // ASCII, with uppercase letters favored
        if ($urandom_range(0, 1)) add_rand_byte(8'($urandom_range(8'h41, 8'h5A)));
        else add_rand_byte(8'($urandom_range(0, 127)));
      end else if (kind < 65) begin
        // Near the table: right lead and middle, random last byte
        case ($urandom_range(0, 3))
          0:       begin lead = LeadE2; mid = Mid80; end
          1:       begin lead = LeadE3; mid = Mid80; end
          2:       begin lead = LeadEF; mid = MidBC; end
          default: begin lead = LeadEF; mid = MidBD; end
        endcase
        add_rand_byte(lead);
        add_rand_byte(mid);
        add_rand_byte(8'h80 | 8'($urandom_range(0, 63)));
      end else if (kind < 75) begin
        // Any well-formed 3-byte sequence
        add_rand_byte(8'hE0 | 8'($urandom_range(0, 15)));
        add_rand_byte(8'h80 | 8'($urandom_range(0, 63)));
        add_rand_byte(8'h80 | 8'($urandom_range(0, 63)));
      end else if (kind < 85) begin
        // Well-formed sequences of the other lengths
        case ($urandom_range(0, 3))
          0:       begin len = 2; lead = 8'hC0 | 8'($urandom_range(0, 31)); end
          1:       begin len = 4; lead = 8'hF0 | 8'($urandom_range(0, 7));  end
          2:       begin len = 5; lead = 8'hF8 | 8'($urandom_range(0, 3));  end
          default: begin len = 6; lead = 8'hFC | 8'($urandom_range(0, 1));  end
        endcase
        add_rand_byte(lead);
        for (int i = 1; i < len; i++) add_rand_byte(8'h80 | 8'($urandom_range(0, 63)));
      end else if (kind < 93) begin
        // Noise: any byte at all
        add_rand_byte(8'($urandom_range(0, 255)));
      end else begin
        // Broken: a multi-byte lead followed by arbitrary bytes
        add_rand_byte(8'($urandom_range(8'hC0, 8'hFD)));
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) add_rand_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Send the text as push requests in bursts of random length with random gaps.
  task automatic send_text;
    int idx;
    int burst;
    int gap;
    idx = 0;
    while (idx < text_q.size()) begin
      burst = $urandom_range(1, 24);
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      while (burst > 0 && idx < text_q.size()) begin
        push <= 1'b1;
        in_i <= text_q[idx];
        @(posedge clk_i);
        // Advance only when the request was taken at this edge.
        if (!full) begin
          idx++;
          burst--;
        end
      end
      // Hold push high across a zero gap so it is not lowered and raised in one step.
      if (idx < text_q.size() && gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    push <= 1'b0;
  endtask

  // Receiver: switch between stall patterns, each held for a phase of random length.
  rx_mode_e rx_mode    = RxFree;
  int       phase_left = 0;
  int       stall_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (phase_left == 0) begin
        rx_mode    = rx_mode_e'($urandom_range(0, 3));
        phase_left = $urandom_range(20, 100);
      end
      phase_left--;
      case (rx_mode)
        RxFree: pop <= 1'b1;
        RxCoin: pop <= 1'($urandom_range(0, 1));
        RxComb: pop <= (phase_left % 4) != 0;
        default: begin
          // Long stalls: now and then drop pop for a stall of random length
          if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
          end else begin
            pop <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 24);
          end
        end
      endcase
    end
  end

  // Watchdog: end the run when no request moves on either side for too long.
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: watchdog, no request accepted for %0d cycles", $time, IdleLimit);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    build_directed();
    build_random();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_text();
    // Drain: sample the outstanding count away from the clock edge so the checker
    // has already counted the last request, then let trailing cycles pass.
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
    $display("Run covered %0d input bytes (%0d text ends) and %0d result bytes,", items, ends,
             results);
    $display("including %0d fullwidth folds; %0d mismatches.", folds, err_cnt);
    if (err_cnt == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/ufaf_pkg.sv
hdl/ufaf_front.sv
hdl/ufaf_queue.sv
hdl/ufaf_back.sv
hdl/utf8_fullwidth_ascii_fold.sv
verif/ufaf_checker.sv
verif/tb_top.sv
